>>> src/vdp_pkg.sv
// ============================================================================
// vdp_pkg
// Shared types, access codes and address helpers for the video memory port.
// ============================================================================
package vdp_pkg;

    // Video memory geometry
    localparam int MEM_ADDR_BITS = 15;

    typedef logic [MEM_ADDR_BITS-1:0] t_mem_idx;
    typedef logic [15:0]              t_word;
    typedef logic [7:0]               t_byte;

    // Bus access codes
    localparam logic [2:0] KIND_MODE_WR    = 3'd0;
    localparam logic [2:0] KIND_ADDR_LO_WR = 3'd1;
    localparam logic [2:0] KIND_ADDR_HI_WR = 3'd2;
    localparam logic [2:0] KIND_DATA_LO_WR = 3'd3;
    localparam logic [2:0] KIND_DATA_HI_WR = 3'd4;
    localparam logic [2:0] KIND_DATA_LO_RD = 3'd5;
    localparam logic [2:0] KIND_DATA_HI_RD = 3'd6;

    // Address step codes
    localparam logic [1:0] STEP_SEL_ONE = 2'd0;
    localparam logic [1:0] STEP_SEL_32  = 2'd1;

    // Address remap codes
    localparam logic [1:0] REMAP_NONE = 2'd0;
    localparam logic [1:0] REMAP_8BIT = 2'd1;
    localparam logic [1:0] REMAP_9BIT = 2'd2;
    localparam logic [1:0] REMAP_10BIT = 2'd3;

    // Byte-lane write request into the video memory
    typedef struct packed {
        logic     en_lo;
        logic     en_hi;
        t_mem_idx idx;
        t_byte    data;
    } t_mem_wr;

    // Rotate the low 8, 9 or 10 address bits left by three, or pass the address unchanged
    function automatic t_word remap_addr(input t_word a, input logic [1:0] sel);
        t_word m;
        unique case (sel)
            REMAP_NONE:  m = a;
            REMAP_8BIT:  m = {a[15:8], a[4:0], a[7:5]};
            REMAP_9BIT:  m = {a[15:9], a[5:0], a[8:6]};
            REMAP_10BIT: m = {a[15:10], a[6:0], a[9:7]};
            default:     m = a;
        endcase
        return m;
    endfunction

    // Address increment selected by the mode byte
    function automatic t_word step_amount(input logic [1:0] sel);
        t_word s;
        unique case (sel)
            STEP_SEL_ONE: s = 16'd1;
            STEP_SEL_32:  s = 16'd32;
            default:      s = 16'd128;
        endcase
        return s;
    endfunction

endpackage

>>> src/vdp_vram.sv
// ============================================================================
// vdp_vram
// Word-organized video memory with byte-lane writes and a registered read.
// ============================================================================
module vdp_vram (
    input  logic              i_clk,
    input  vdp_pkg::t_mem_wr  i_wr,
    input  logic              i_rd_en,
    input  vdp_pkg::t_mem_idx i_rd_idx,
    output vdp_pkg::t_word    o_rd_data
);

    vdp_pkg::t_word mem [2**vdp_pkg::MEM_ADDR_BITS];
    vdp_pkg::t_word r_rd_data;

    // Byte-lane writes
    always_ff @(posedge i_clk) begin
        if (i_wr.en_lo) begin
            mem[i_wr.idx][7:0] <= i_wr.data;
        end
        if (i_wr.en_hi) begin
            mem[i_wr.idx][15:8] <= i_wr.data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/vram_data_port_core.sv
// ============================================================================
// vram_data_port_core
// Byte-wide bus port onto the word-organized video memory.
// ============================================================================
// Every bus access returns one result byte, loaded into the output register
// in the cycle the access is accepted, so a read returns the prefetch byte
// held before the access. Mode writes, data writes and non-advancing reads
// do not set the busy flag. Address writes and the advancing data read do:
// the memory's registered read port is read as the access is accepted, the
// prefetch latch loads from it while busy, and no access is accepted
// meanwhile. The memory holds 2**MEM_ADDR_BITS words, indexed by the low
// bits of the remapped address, and its contents are undefined until
// written. While the memory is not accessible, data writes are dropped and refills load zero.
module vram_data_port_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_write_byte,
    input  logic        i_accessible,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_read_byte
);

    vdp_pkg::t_word   r_addr;
    vdp_pkg::t_word   n_addr;
    vdp_pkg::t_word   r_prefetch;
    logic             r_step_high;
    logic [1:0]       r_remap_sel;
    logic [1:0]       r_step_sel;
    logic             r_busy;
    logic             r_ok;
    logic             r_out_valid;
    vdp_pkg::t_byte   r_out_byte;
    vdp_pkg::t_byte   n_out_byte;
    logic             n_refill;
    logic             acc;
    vdp_pkg::t_word   rd_addr;
    vdp_pkg::t_word   wr_map;
    vdp_pkg::t_word   rd_map;
    vdp_pkg::t_word   step_addr;
    vdp_pkg::t_word   mem_rdata;
    vdp_pkg::t_mem_wr mem_wr;

    assign o_in_ready      = !r_busy && (!r_out_valid || i_out_ready);
    assign acc             = i_in_valid && o_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_read_byte = r_out_byte;

    assign step_addr = r_addr + vdp_pkg::step_amount(r_step_sel);

    // Access decode: next address, refill request, result byte
    always_comb begin
        n_addr     = r_addr;
        n_refill   = 1'b0;
        n_out_byte = '0;
        unique case (i_kind)
            vdp_pkg::KIND_ADDR_LO_WR: begin
                n_addr   = {r_addr[15:8], i_write_byte};
                n_refill = 1'b1;
            end
            vdp_pkg::KIND_ADDR_HI_WR: begin
                n_addr   = {i_write_byte, r_addr[7:0]};
                n_refill = 1'b1;
            end
            vdp_pkg::KIND_DATA_LO_WR: begin
                if (!r_step_high) begin
                    n_addr = step_addr;
                end
            end
            vdp_pkg::KIND_DATA_HI_WR: begin
                if (r_step_high) begin
                    n_addr = step_addr;
                end
            end
            vdp_pkg::KIND_DATA_LO_RD: begin
                n_out_byte = r_prefetch[7:0];
                if (!r_step_high) begin
                    n_addr   = step_addr;
                    n_refill = 1'b1;
                end
            end
            vdp_pkg::KIND_DATA_HI_RD: begin
                n_out_byte = r_prefetch[15:8];
                if (r_step_high) begin
                    n_addr   = step_addr;
                    n_refill = 1'b1;
                end
            end
            default: begin
                n_addr = r_addr;
            end
        endcase
    end

    // Refill after an address write uses the new address, else the current one
    assign rd_addr = (i_kind == vdp_pkg::KIND_ADDR_LO_WR ||
                      i_kind == vdp_pkg::KIND_ADDR_HI_WR) ? n_addr : r_addr;

    assign wr_map = vdp_pkg::remap_addr(r_addr, r_remap_sel);
    assign rd_map = vdp_pkg::remap_addr(rd_addr, r_remap_sel);

    // Data writes go to the current remapped address
    always_comb begin
        mem_wr.en_lo = acc && i_accessible && (i_kind == vdp_pkg::KIND_DATA_LO_WR);
        mem_wr.en_hi = acc && i_accessible && (i_kind == vdp_pkg::KIND_DATA_HI_WR);
        mem_wr.idx   = wr_map[vdp_pkg::MEM_ADDR_BITS-1:0];
        mem_wr.data  = i_write_byte;
    end

    vdp_vram u_vram (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (acc && n_refill),
        .i_rd_idx  (rd_map[vdp_pkg::MEM_ADDR_BITS-1:0]),
        .o_rd_data (mem_rdata)
    );

    // Port state, refill sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_prefetch  <= '0;
            r_step_high <= 1'b0;
            r_remap_sel <= vdp_pkg::REMAP_NONE;
            r_step_sel  <= vdp_pkg::STEP_SEL_ONE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_addr      <= n_addr;
                r_busy      <= n_refill;
                r_ok        <= i_accessible;
                r_out_valid <= 1'b1;
                r_out_byte  <= n_out_byte;
                if (i_kind == vdp_pkg::KIND_MODE_WR) begin
                    r_step_sel  <= i_write_byte[1:0];
                    r_remap_sel <= i_write_byte[3:2];
                    r_step_high <= i_write_byte[7];
                end
            end else begin
                r_busy <= 1'b0;
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
            // Busy after a refilling access: load the prefetch latch
            if (r_busy) begin
                r_prefetch <= r_ok ? mem_rdata : '0;
            end
        end
    end

    // The busy flag of a refill does not persist beyond the prefetch load
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("refill cycle lasted more than one cycle");

    // No access accepted during a refill
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_in_ready)
        else $error("access accepted during refill");

    // Non-read accesses return zero
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind != vdp_pkg::KIND_DATA_LO_RD && i_kind != vdp_pkg::KIND_DATA_HI_RD)
        |=> (o_out_read_byte == 8'd0))
        else $error("non-read access returned nonzero byte");

    // Refill while inaccessible loads zero
    a_blank_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_ok) |=> (r_prefetch == 16'd0))
        else $error("inaccessible refill loaded nonzero word");

endmodule
